// ===== hw/rtl/htc_pkg.sv =====
// shared types and fixed-point constants for humidity and temperature compensation
package htc_pkg;

	localparam int RAW_T_W = 14;
	localparam int RAW_H_W = 12;
	localparam int TEMP_W  = 15;
	localparam int HUM_W   = 14;
	localparam int FRAC_W  = 24;

	// internal datapath widths
	localparam int RHSQ_W  = 2 * RAW_H_W;
	localparam int LIN_W   = 34;
	localparam int SLOPE_W = 23;
	localparam int PROD_W  = 39;
	localparam int ACC_W   = 42;
	localparam int RND_W   = ACC_W - FRAC_W;

	typedef logic [RAW_T_W-1:0]        raw_temp_t;
	typedef logic [RAW_H_W-1:0]        raw_hum_t;
	typedef logic signed [TEMP_W-1:0]  temp_t;
	typedef logic [HUM_W-1:0]          hum_t;
	typedef logic signed [ACC_W-1:0]   acc_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	// coefficients at 2^-24 scaling
	localparam logic signed [LIN_W-1:0] K_C1 = -LIN_W'(67108864);
	localparam logic signed [LIN_W-1:0] K_C2 = LIN_W'(679477);
	localparam logic [SLOPE_W-1:0]      K_T1 = SLOPE_W'(167772);
	localparam logic [SLOPE_W-1:0]      K_T2 = SLOPE_W'(1342);

	// linear term scaled to hundredths, quadratic term folded with the same factor
	localparam acc_t K_PCT_SCALE = ACC_W'(100);
	localparam acc_t K_C3_SCALED = -ACC_W'(4700);

	localparam temp_t T_OFFSET = TEMP_W'(3966);
	localparam temp_t T_REF    = TEMP_W'(2500);

	localparam acc_t K_LOW_LIMIT = ACC_W'(10) <<< FRAC_W;
	localparam acc_t K_HALF      = ACC_W'(1) <<< (FRAC_W - 1);

	localparam hum_t HUM_MIN = HUM_W'(10);
	localparam hum_t HUM_MAX = HUM_W'(10000);

	// stage 2 to stage 3 hand-off
	typedef struct packed {
		logic  valid;
		temp_t tc;
		acc_t  lin100;
		prod_t prod;
	} htc_mid_t;

endpackage

// ===== hw/rtl/htc_if.sv =====
// request channel interfaces for raw samples and compensated results
interface htc_sample_if;
	import htc_pkg::*;

	logic      valid;
	logic      ready;
	raw_temp_t raw_temperature;
	raw_hum_t  raw_humidity;

	modport source (output valid, output raw_temperature, output raw_humidity, input ready);
	modport sink   (input valid, input raw_temperature, input raw_humidity, output ready);
endinterface

interface htc_result_if;
	import htc_pkg::*;

	logic  valid;
	logic  ready;
	temp_t temperature_centi;
	hum_t  humidity_centi;

	modport source (output valid, output temperature_centi, output humidity_centi, input ready);
	modport sink   (input valid, input temperature_centi, input humidity_centi, output ready);
endinterface

// ===== hw/rtl/humidity_temperature_compensation_top.sv =====
// four register stages s1 to s4; a taken sample request is registered in s1, then s2 and s3,
// then the output register s4; one request per cycle unless the output stalls
// multiplies sit in s1 and s2, s3 adds, s4 rounds and clamps
// a stalled output holds its result; bubbles in earlier stages still take new requests
// reset (arst_n low) clears every stage valid bit at once; data registers are not reset
// no stored state between requests, so results depend only on their own sample
module humidity_temperature_compensation_top (
	input  logic          clk,
	input  logic          arst_n,
	htc_sample_if.sink    sample,
	htc_result_if.source  result
);
	import htc_pkg::*;

	// stage 2 payload and its backpressure from stage 3
	htc_mid_t mid;
	logic     mid_ready;

	// s1: temperature offset, rh squared, linear and slope terms
	// s2: scaled quadratic sum and (t - 25) product
	htc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.down_ready (mid_ready),
		.mid        (mid)
	);

	// s3: accumulate in 2^-24 hundredths of a percent
	// s4: round, clamp to 10..10000, hold for the result request
	htc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid      (mid),
		.up_ready (mid_ready),
		.result   (result)
	);

endmodule

// ===== hw/rtl/htc_front.sv =====
// stages 1 and 2: offset temperature, polynomial terms and temperature product
module htc_front (
	input  logic               clk,
	input  logic               arst_n,
	htc_sample_if.sink         sample,
	input  logic               down_ready,
	output htc_pkg::htc_mid_t  mid
);
	import htc_pkg::*;

	logic en_s1;
	logic en_s2;

	// stage 1 registers
	logic                      valid_s1;
	temp_t                     tc_s1;
	temp_t                     dt_s1;
	logic [RHSQ_W-1:0]         rhsq_s1;
	logic signed [LIN_W-1:0]   linp_s1;
	logic [SLOPE_W-1:0]        slope_s1;

	// stage 2 registers
	logic                      valid_s2;
	temp_t                     tc_s2;
	acc_t                      lin100_s2;
	prod_t                     prod_s2;

	// stage 1 logic
	temp_t                     tc_w;
	logic signed [LIN_W-1:0]   rh_l;
	logic [SLOPE_W-1:0]        rh_sl;
	logic [RHSQ_W-1:0]         rh_sq;

	// stage 2 logic
	acc_t                      linp_x;
	acc_t                      rhsq_x;
	prod_t                     dt_x;
	prod_t                     slope_x;

	assign en_s2 = !valid_s2 || down_ready;
	assign en_s1 = !valid_s1 || en_s2;
	assign sample.ready = en_s1;

	assign tc_w  = $signed({1'b0, sample.raw_temperature}) - T_OFFSET;
	assign rh_l  = LIN_W'($signed({1'b0, sample.raw_humidity}));
	assign rh_sl = SLOPE_W'(sample.raw_humidity);
	assign rh_sq = RHSQ_W'(sample.raw_humidity) * RHSQ_W'(sample.raw_humidity);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			tc_s1    <= tc_w;
			dt_s1    <= tc_w - T_REF;
			rhsq_s1  <= rh_sq;
			linp_s1  <= K_C1 + K_C2 * rh_l;
			slope_s1 <= K_T1 + K_T2 * rh_sl;
		end
	end

	assign linp_x  = ACC_W'(linp_s1);
	assign rhsq_x  = ACC_W'($signed({1'b0, rhsq_s1}));
	assign dt_x    = PROD_W'(dt_s1);
	assign slope_x = PROD_W'($signed({1'b0, slope_s1}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// linearised humidity times 100, and (t - 25) times the correction slope
	always_ff @(posedge clk) begin
		if (en_s2) begin
			tc_s2     <= tc_s1;
			lin100_s2 <= linp_x * K_PCT_SCALE + rhsq_x * K_C3_SCALED;
			prod_s2   <= dt_x * slope_x;
		end
	end

	assign mid.valid  = valid_s2;
	assign mid.tc     = tc_s2;
	assign mid.lin100 = lin100_s2;
	assign mid.prod   = prod_s2;

endmodule

// ===== hw/rtl/htc_back.sv =====
// stages 3 and 4: sum, rounding and clamping into the result register
module htc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  htc_pkg::htc_mid_t  mid,
	output logic               up_ready,
	htc_result_if.source       result
);
	import htc_pkg::*;

	logic en_s3;
	logic en_s4;

	logic              valid_s3;
	temp_t             tc_s3;
	acc_t              acc_s3;

	logic              valid_s4;
	temp_t             tc_s4;
	hum_t              hum_s4;

	acc_t              rnd_w;
	logic [RND_W-1:0]  whole_w;
	hum_t              hum_w;

	assign en_s4    = !valid_s4 || result.ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign up_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= mid.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			tc_s3  <= mid.tc;
			acc_s3 <= mid.lin100 + ACC_W'(mid.prod);
		end
	end

	// round half up, then clamp to the valid humidity span
	assign rnd_w   = acc_s3 + K_HALF;
	assign whole_w = rnd_w[ACC_W-1:FRAC_W];

	always_comb begin
		priority if (acc_s3 <= K_LOW_LIMIT) begin
			hum_w = HUM_MIN;
		end else if (whole_w > RND_W'(HUM_MAX)) begin
			hum_w = HUM_MAX;
		end else begin
			hum_w = whole_w[HUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			tc_s4  <= tc_s3;
			hum_s4 <= hum_w;
		end
	end

	assign result.valid             = valid_s4;
	assign result.temperature_centi = tc_s4;
	assign result.humidity_centi    = hum_s4;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for the humidity and temperature compensation pipeline
module testbench;
	import htc_pkg::*;

	// sensor coefficients as signed integers at 2^-24 scaling
	localparam longint FX_C1 = -67108864;
	localparam longint FX_C2 = 679477;
	localparam longint FX_C3 = -47;
	localparam longint FX_T1 = 167772;
	localparam longint FX_T2 = 1342;
	localparam int     FX_SHIFT = 24;

	// raw temperature count at zero degrees, and the 25 degree reference, in centidegrees
	localparam longint ZERO_C_CENTI = 3966;
	localparam longint REF_CENTI    = 2500;
	localparam longint PCT_TO_CENTI = 100;

	// output humidity limits in hundredths of a percent
	localparam longint RH_FLOOR = 10;
	localparam longint RH_CEIL  = 10000;

	localparam int N_DIRECTED = 22;
	localparam int N_RANDOM   = 800;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		temp_t temperature;
		hum_t  humidity;
	} reading_t;

	// one directed request; known marks rows whose result is typed in below
	typedef struct packed {
		raw_temp_t raw_t;
		raw_hum_t  raw_h;
		logic      known;
		temp_t     known_temp;
		hum_t      known_hum;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic full_rate;

	htc_sample_if sample_ch();
	htc_result_if result_ch();

	humidity_temperature_compensation_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	reading_t expected_readings[$];
	int       requests_sent;
	int       results_compared = 0;
	int       mismatches = 0;
	int       low_clamps = 0;
	int       high_clamps = 0;
	int       ready_hold;

	// directed requests: corners of both raw fields, the clamps, rounding near the
	// low clamp at 25 degrees, the 100 percent crossing, and alternating bit patterns
	stim_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{0,     0,    1'b1, -3966, 10},     // coldest and driest: low clamp
		'{16383, 4095, 1'b1, 12417, 10000},  // hottest and wettest: high clamp
		'{3966,  0,    1'b1, 0,     10},     // exactly zero degrees
		'{16383, 0,    1'b1, 12417, 10},     // hot but dry: still below the floor
		'{6466,  0,    1'b1, 2500,  10},     // reference temperature, no correction
		'{0,     4095, 1'b0, 0,     0},
		'{6466,  98,   1'b0, 0,     0},
		'{6466,  99,   1'b0, 0,     0},
		'{6466,  100,  1'b0, 0,     0},
		'{6466,  101,  1'b0, 0,     0},
		'{6466,  102,  1'b0, 0,     0},
		'{6466,  103,  1'b0, 0,     0},
		'{6466,  3335, 1'b0, 0,     0},
		'{6466,  3339, 1'b0, 0,     0},
		'{6466,  3342, 1'b0, 0,     0},
		'{6466,  3345, 1'b0, 0,     0},
		'{10922, 2730, 1'b0, 0,     0},
		'{5461,  1365, 1'b0, 0,     0},
		'{3965,  2048, 1'b0, 0,     0},
		'{8192,  1,    1'b0, 0,     0},
		'{16383, 2048, 1'b0, 0,     0},
		'{0,     3500, 1'b0, 0,     0}
	};

	// linearize, correct for temperature, round half up, then clamp
	function automatic reading_t predict_reading(raw_temp_t raw_t, raw_hum_t raw_h);
		longint   rh;
		longint   tc;
		longint   lin;
		longint   acc;
		longint   rounded;
		reading_t r;
		rh  = longint'(raw_h);
		tc  = longint'(raw_t) - ZERO_C_CENTI;
		lin = FX_C1 + FX_C2 * rh + FX_C3 * rh * rh;
		acc = PCT_TO_CENTI * lin + (tc - REF_CENTI) * (FX_T1 + FX_T2 * rh);
		// anything at or below the floor, negatives included, reads as the floor
		if (acc <= (RH_FLOOR <<< FX_SHIFT)) begin
			rounded = RH_FLOOR;
		end else begin
			rounded = (acc + (longint'(1) <<< (FX_SHIFT - 1))) >>> FX_SHIFT;
			if (rounded > RH_CEIL) begin
				rounded = RH_CEIL;
			end
		end
		r.temperature = temp_t'(tc);
		r.humidity    = hum_t'(rounded);
		return r;
	endfunction

	// mostly back to back, sometimes a short gap, rarely a long one; never a gap with no_gaps
	function automatic int pick_gap(bit no_gaps);
		int roll;
		roll = $urandom_range(99);
		if (no_gaps || roll < 60) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// present one request, hold it until taken, then record what it should produce
	task automatic send_sample(raw_temp_t raw_t, raw_hum_t raw_h, reading_t want, bit no_gaps);
		int gap;
		gap = pick_gap(no_gaps);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid           <= 1'b1;
		sample_ch.raw_temperature <= raw_t;
		sample_ch.raw_humidity    <= raw_h;
		do @(posedge clk); while (!sample_ch.ready);
		expected_readings.push_back(want);
		requests_sent++;
	endtask

	// stop sending until the pipeline has handed back every outstanding result
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_readings.size() != 0);
	endtask

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side backpressure: runs of ready, short stalls, now and then a long stall; always ready at full rate
	always @(posedge clk) begin : stall_gen
		int roll;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			ready_hold      <= 0;
		end else if (full_rate) begin
			result_ch.ready <= 1'b1;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			roll = $urandom_range(99);
			if (roll < 70) begin
				result_ch.ready <= 1'b1;
				ready_hold      <= $urandom_range(1, 20);
			end else if (roll < 95) begin
				result_ch.ready <= 1'b0;
				ready_hold      <= $urandom_range(1, 3);
			end else begin
				result_ch.ready <= 1'b0;
				ready_hold      <= $urandom_range(10, 40);
			end
		end
	end

	// compare every result taken against the oldest outstanding expectation
	always @(posedge clk) begin : result_check
		reading_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_readings.size() == 0) begin
				$display("%0t: unexpected result temperature_centi %0d humidity_centi %0d",
					$time, result_ch.temperature_centi, result_ch.humidity_centi);
				mismatches++;
			end else begin
				want = expected_readings.pop_front();
				results_compared++;
				if (result_ch.temperature_centi !== want.temperature) begin
					$display("%0t: temperature_centi expected %0d got %0d",
						$time, want.temperature, result_ch.temperature_centi);
					mismatches++;
				end
				if (result_ch.humidity_centi !== want.humidity) begin
					$display("%0t: humidity_centi expected %0d got %0d",
						$time, want.humidity, result_ch.humidity_centi);
					mismatches++;
				end
				if (want.humidity == hum_t'(RH_FLOOR)) begin
					low_clamps++;
				end
				if (want.humidity == hum_t'(RH_CEIL)) begin
					high_clamps++;
				end
			end
		end
	end

	initial begin : stimulus
		int        roll;
		bit        no_gaps;
		raw_temp_t raw_t;
		raw_hum_t  raw_h;
		reading_t  want;
		sample_ch.valid           = 1'b0;
		sample_ch.raw_temperature = '0;
		sample_ch.raw_humidity    = '0;
		arst_n                    = 1'b0;
		full_rate                 = 1'b0;
		requests_sent             = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: typed results where obvious, the predictor elsewhere
		foreach (directed_rows[i]) begin
			if (directed_rows[i].known) begin
				want.temperature = directed_rows[i].known_temp;
				want.humidity    = directed_rows[i].known_hum;
			end else begin
				want = predict_reading(directed_rows[i].raw_t, directed_rows[i].raw_h);
			end
			send_sample(directed_rows[i].raw_t, directed_rows[i].raw_h, want, 1'b0);
		end
		drain_results();

		// random requests; every third block of a hundred runs with no idling at all
		for (int n = 0; n < N_RANDOM; n++) begin
			no_gaps = ((n / 100) % 3) == 2;
			full_rate <= no_gaps;
			if (n == N_RANDOM / 2) begin
				drain_results();
			end
			roll  = $urandom_range(99);
			raw_t = raw_temp_t'($urandom);
			raw_h = raw_hum_t'($urandom);
			if (roll >= 60 && roll < 80) begin
				// dry end, where the low clamp and its neighborhood live
				raw_h = raw_hum_t'($urandom_range(0, 320));
			end else if (roll >= 80) begin
				// wet and warm, pushing toward the high clamp
				raw_h = raw_hum_t'($urandom_range(2800, 4095));
				raw_t = raw_temp_t'($urandom_range(6466, 16383));
			end
			send_sample(raw_t, raw_h, predict_reading(raw_t, raw_h), no_gaps);
		end

		full_rate <= 1'b0;
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_readings.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_readings.size());
		end
		$display("sent %0d sample requests (%0d directed), compared %0d results",
			requests_sent, N_DIRECTED, results_compared);
		$display("humidity at the low clamp %0d times, at the high clamp %0d times",
			low_clamps, high_clamps);
		if (mismatches == 0 && expected_readings.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
